// ===== rtl/softmax_weighted_pool_2x2_macros.svh =====
`ifndef SOFTMAX_WEIGHTED_POOL_2X2_MACROS_SVH
`define SOFTMAX_WEIGHTED_POOL_2X2_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SWP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SWP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/swp_pkg.sv =====
package swp_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int SAMPLE_W   = 16;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int WSUM_W     = 50;
    localparam int WTSUM_W    = 34;
    localparam int WGT_W      = 32;
    localparam int OP_W       = 64;
    localparam int SER_TERMS  = 20;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [OP_W-1:0] Q48_ONE = 64'h0001_0000_0000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SER_MUL,
        S_SER_DIV,
        S_POW_MUL,
        S_WGT,
        S_WGT_DIV,
        S_WX_MUL,
        S_UPD,
        S_Q_DIV,
        S_EMIT
    } state_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } alu_op_t;

    // a is the multiplicand or the divisor, b the multiplier or the dividend
    typedef struct packed {
        logic            start;
        alu_op_t         op;
        logic [OP_W-1:0] a;
        logic [OP_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [2*OP_W-1:0] result;
    } alu_rsp_t;

endpackage

// ===== rtl/swp_alu.sv =====
module swp_alu
    import swp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    localparam int CNT_W = $clog2(OP_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    alu_op_t           op_reg, op_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [2*OP_W-1:0] acc_reg, acc_next;
    logic [OP_W-1:0]   a_reg, a_next;
    logic [OP_W-1:0]   b_reg, b_next;

    logic [OP_W:0]     trial;
    logic [OP_W:0]     diff;
    logic              ge;

    always_comb
    begin
        trial = {acc_reg[OP_W-1:0], b_reg[OP_W-1]};
        diff  = trial - {1'b0, a_reg};
        ge    = (trial >= {1'b0, a_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (busy_reg)
        begin
            if (op_reg == OP_MUL)
            begin
                acc_next = {acc_reg[2*OP_W-2:0], 1'b0}
                         + (b_reg[OP_W-1] ? {{OP_W{1'b0}}, a_reg} : '0);
                b_next   = {b_reg[OP_W-2:0], 1'b0};
            end
            else
            begin
                // restoring step: remainder in acc, quotient shifts into b
                acc_next = {{(OP_W-1){1'b0}}, (ge ? diff : trial)};
                b_next   = {b_reg[OP_W-2:0], ge};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(OP_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            acc_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    always_comb
    begin
        rsp.busy   = busy_reg;
        rsp.done   = done_reg;
        rsp.result = (op_reg == OP_MUL) ? acc_reg : {{OP_W{1'b0}}, b_reg};
    end

endmodule

// ===== rtl/softmax_weighted_pool_2x2.sv =====
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata[15:0] sample_value
// m_       out  m_tvalid/m_tready  m_tdata[15:0] pooled_value, m_tlast last_in_plane
// cfg_     in   cfg_we             cfg_addr index, cfg_data value
//
// All multiplies and divides run through one bit-serial multiply/divide unit.
// An in-window sample runs a 20-term exp series, two ops a term, then one multiply
// per integer part of |x|, a divide for negative x, the product and, on a window's
// last sample, the quotient; the first in-window sample after reset runs the series
// twice to form e^1. Samples in an ignored odd row or column are taken in S_IDLE.
// rst_n clears control state; the line stores are not cleared.
// s_tready is low while a sample is in work; a result waiting on m_tready stalls
// only the final transfer into the output register.
module softmax_weighted_pool_2x2
    import swp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,    // [15:0] sample_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,    // [15:0] pooled_value
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    `include "softmax_weighted_pool_2x2_macros.svh"

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = $clog2(LINE_DEPTH);

    state_t state_reg, state_next;
    logic   issued_reg;
    logic   e1_valid_reg;
    logic   out_valid_reg;
    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;
    logic [FW_W-1:0] col_reg;
    logic [FH_W-1:0] row_reg;

    logic [SAMPLE_W-1:0] absx_reg;
    logic                neg_reg;
    logic [12:0]         t_reg;
    logic [4:0]          n_reg;
    logic [3:0]          qcnt_reg;
    logic                doing_e1_reg;
    logic [OP_W-1:0]     term_reg, sum_reg, prod_reg, e1_reg, r_reg, d_reg;
    logic [WGT_W-1:0]    w_reg;
    logic [WSUM_W-1:0]   wx_reg, num_reg;
    logic [WTSUM_W-1:0]  den_reg;
    logic [AW-1:0]       idx_reg;
    logic                first_reg, last_reg, lastplane_reg;
    logic [SAMPLE_W-1:0] qres_reg, out_data_reg;
    logic                out_last_reg;

    logic [WSUM_W-1:0]  wsum_mem [LINE_DEPTH];
    logic [WTSUM_W-1:0] wt_mem   [LINE_DEPTH];
    logic [WSUM_W-1:0]  wsum_rd_reg;
    logic [WTSUM_W-1:0] wt_rd_reg;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic                accept;
    logic                in_range;
    logic [SAMPLE_W-1:0] absx;
    logic [FW_W-1:0]     fw_even;
    logic [FH_W-1:0]     fh_even;
    logic [FW_W-1:0]     col_inc;
    logic [FH_W-1:0]     row_inc;
    logic [OP_W-1:0]     ser_sum;
    logic [WSUM_W-1:0]   wsum_new;
    logic [WTSUM_W-1:0]  wt_new;
    logic [WSUM_W-1:0]   mag;
    logic [OP_W-1:0]     qm;
    logic [OP_W-1:0]     d_calc;

    swp_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    always_comb
    begin
        fw_even  = {fw_reg[FW_W-1:1], 1'b0};
        fh_even  = {fh_reg[FH_W-1:1], 1'b0};
        accept   = s_tvalid && s_tready;
        in_range = (col_reg < fw_even) && (row_reg < fh_even);
        absx     = s_tdata[SAMPLE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
        col_inc  = col_reg + 1'b1;
        row_inc  = row_reg + 1'b1;
        ser_sum  = sum_reg + alu_rsp.result[OP_W-1:0];
        wsum_new = first_reg ? wx_reg : (wsum_rd_reg + wx_reg);
        wt_new   = first_reg ? WTSUM_W'(w_reg) : (wt_rd_reg + WTSUM_W'(w_reg));
        mag      = num_reg[WSUM_W-1] ? (~num_reg + 1'b1) : num_reg;
        qm       = alu_rsp.result[OP_W-1:0];
        d_calc   = (r_reg + 64'(1 << 19)) >> 20;
        if (d_calc == '0)
        begin
            d_calc = 64'd1;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_range && !cfg_we)
                begin
                    state_next = S_SER_MUL;
                end
            end
            S_SER_MUL:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_SER_DIV;
                end
            end
            S_SER_DIV:
            begin
                if (alu_rsp.done)
                begin
                    if (n_reg == 5'(SER_TERMS) && !doing_e1_reg)
                    begin
                        state_next = (qcnt_reg != '0) ? S_POW_MUL : S_WGT;
                    end
                    else
                    begin
                        state_next = S_SER_MUL;
                    end
                end
            end
            S_POW_MUL:
            begin
                if (alu_rsp.done && qcnt_reg == 4'd1)
                begin
                    state_next = S_WGT;
                end
            end
            S_WGT:
            begin
                state_next = neg_reg ? S_WGT_DIV : S_WX_MUL;
            end
            S_WGT_DIV:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_WX_MUL;
                end
            end
            S_WX_MUL:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                state_next = last_reg ? S_Q_DIV : S_IDLE;
            end
            S_Q_DIV:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // requests to the shared unit
    always_comb
    begin
        alu_req.start = 1'b0;
        alu_req.op    = OP_MUL;
        alu_req.a     = term_reg;
        alu_req.b     = 64'(t_reg);
        case (state_reg)
            S_SER_MUL:
            begin
                alu_req.start = !issued_reg;
            end
            S_SER_DIV:
            begin
                alu_req.start = !issued_reg;
                alu_req.op    = OP_DIV;
                alu_req.a     = 64'(n_reg);
                alu_req.b     = prod_reg >> 12;
            end
            S_POW_MUL:
            begin
                alu_req.start = !issued_reg;
                alu_req.a     = r_reg;
                alu_req.b     = e1_reg;
            end
            S_WGT_DIV:
            begin
                alu_req.start = !issued_reg;
                alu_req.op    = OP_DIV;
                alu_req.a     = d_reg;
                alu_req.b     = Q48_ONE + (d_reg >> 1);
            end
            S_WX_MUL:
            begin
                alu_req.start = !issued_reg;
                alu_req.a     = 64'(w_reg);
                alu_req.b     = 64'(absx_reg);
            end
            S_Q_DIV:
            begin
                alu_req.start = !issued_reg;
                alu_req.op    = OP_DIV;
                alu_req.a     = 64'(den_reg);
                alu_req.b     = 64'(mag);
            end
            default:
            begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            e1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fw_reg        <= FW_W'(64);
            fh_reg        <= FH_W'(64);
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (alu_req.start)
            begin
                issued_reg <= 1'b1;
            end
            else if (alu_rsp.done)
            begin
                issued_reg <= 1'b0;
            end
            if (state_reg == S_SER_DIV && alu_rsp.done && doing_e1_reg
                && n_reg == 5'(SER_TERMS))
            begin
                e1_valid_reg <= 1'b1;
            end
            if (state_reg == S_EMIT && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                col_reg <= '0;
                row_reg <= '0;
                if (cfg_addr == REG_FRAME_WIDTH)
                begin
                    if (cfg_data[FW_W-1:0] < FW_W'(2))
                    begin
                        fw_reg <= FW_W'(2);
                    end
                    else if (32'(cfg_data[FW_W-1:0]) > MAX_WIDTH)
                    begin
                        fw_reg <= FW_W'(MAX_WIDTH);
                    end
                    else
                    begin
                        fw_reg <= cfg_data[FW_W-1:0];
                    end
                end
                else
                begin
                    if (cfg_data < FH_W'(2))
                    begin
                        fh_reg <= FH_W'(2);
                    end
                    else if (32'(cfg_data) > MAX_HEIGHT)
                    begin
                        fh_reg <= FH_W'(MAX_HEIGHT);
                    end
                    else
                    begin
                        fh_reg <= cfg_data;
                    end
                end
            end
            else if (accept)
            begin
                if (col_inc >= fw_reg)
                begin
                    col_reg <= '0;
                    row_reg <= (row_inc >= fh_reg) ? '0 : row_inc;
                end
                else
                begin
                    col_reg <= col_inc;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    absx_reg      <= absx;
                    neg_reg       <= s_tdata[SAMPLE_W-1];
                    qcnt_reg      <= absx[SAMPLE_W-1:12];
                    idx_reg       <= AW'(col_reg >> 1);
                    first_reg     <= !row_reg[0] && !col_reg[0];
                    last_reg      <= row_reg[0] && col_reg[0];
                    lastplane_reg <= (row_reg == fh_even - 1'b1)
                                  && (col_reg == fw_even - 1'b1);
                    doing_e1_reg  <= !e1_valid_reg;
                    t_reg         <= e1_valid_reg ? {1'b0, absx[11:0]} : 13'd4096;
                    term_reg      <= Q48_ONE;
                    sum_reg       <= Q48_ONE;
                    n_reg         <= 5'd1;
                end
            end
            S_SER_MUL:
            begin
                if (alu_rsp.done)
                begin
                    prod_reg <= alu_rsp.result[OP_W-1:0];
                end
            end
            S_SER_DIV:
            begin
                if (alu_rsp.done)
                begin
                    if (n_reg == 5'(SER_TERMS))
                    begin
                        if (doing_e1_reg)
                        begin
                            // e^1 done, now the fractional part
                            e1_reg       <= ser_sum;
                            doing_e1_reg <= 1'b0;
                            t_reg        <= {1'b0, absx_reg[11:0]};
                            term_reg     <= Q48_ONE;
                            sum_reg      <= Q48_ONE;
                            n_reg        <= 5'd1;
                        end
                        else
                        begin
                            r_reg <= ser_sum;
                        end
                    end
                    else
                    begin
                        term_reg <= alu_rsp.result[OP_W-1:0];
                        sum_reg  <= ser_sum;
                        n_reg    <= n_reg + 1'b1;
                    end
                end
            end
            S_POW_MUL:
            begin
                if (alu_rsp.done)
                begin
                    r_reg    <= alu_rsp.result[OP_W+47:48];
                    qcnt_reg <= qcnt_reg - 1'b1;
                end
            end
            S_WGT:
            begin
                if (neg_reg)
                begin
                    d_reg <= d_calc;
                end
                else
                begin
                    w_reg <= WGT_W'((r_reg + 64'(1 << 27)) >> 28);
                end
            end
            S_WGT_DIV:
            begin
                if (alu_rsp.done)
                begin
                    w_reg <= alu_rsp.result[WGT_W-1:0];
                end
            end
            S_WX_MUL:
            begin
                if (alu_rsp.done)
                begin
                    wx_reg <= neg_reg ? (~alu_rsp.result[WSUM_W-1:0] + 1'b1)
                                      : alu_rsp.result[WSUM_W-1:0];
                end
            end
            S_UPD:
            begin
                num_reg <= wsum_new;
                den_reg <= wt_new;
            end
            S_Q_DIV:
            begin
                if (alu_rsp.done)
                begin
                    if (num_reg[WSUM_W-1])
                    begin
                        qres_reg <= (qm > 64'd32768) ? 16'h8000 : (~qm[15:0] + 1'b1);
                    end
                    else
                    begin
                        qres_reg <= (qm > 64'd32767) ? 16'h7FFF : qm[15:0];
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    out_data_reg <= qres_reg;
                    out_last_reg <= lastplane_reg;
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    // line stores
    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPD)
        begin
            wsum_mem[idx_reg] <= wsum_new;
            wt_mem[idx_reg]   <= wt_new;
        end
        wsum_rd_reg <= wsum_mem[idx_reg];
        wt_rd_reg   <= wt_mem[idx_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `SWP_ASSERT_IMPL(a_ready_unit_idle, s_tready, !alu_rsp.busy, "sample taken while unit busy")
    `SWP_ASSERT_IMPL(a_done_in_work, alu_rsp.done, state_reg != S_IDLE, "unit result lost")
    `SWP_ASSERT_NEXT(a_cfg_restart, cfg_we, (col_reg == '0) && (row_reg == '0), "no restart")

endmodule

// ===== bench/tb_softmax_weighted_pool_2x2.sv =====
`timescale 1ns / 1ps

module tb_softmax_weighted_pool_2x2;
    import swp_pkg::*;

    class pool_scoreboard;
        typedef struct {
            logic [15:0] value;
            logic        last;
        } pooled_t;

        pooled_t            pending[$];
        longint             wx_line[512];
        longint unsigned    w_line[512];
        int unsigned        row;
        int unsigned        col;
        int unsigned        width;
        int unsigned        height;
        longint unsigned    e_one;
        int                 errors;
        int                 n_samples;
        int                 n_results;

        function new();
            e_one = exp_q48(4096);
            row = 0;
            col = 0;
            width = 64;
            height = 64;
            errors = 0;
            n_samples = 0;
            n_results = 0;
        endfunction

        // e^(t/4096) in Q.48, t in 0..4096
        function longint unsigned exp_q48(longint unsigned t);
            longint unsigned acc;
            longint unsigned term;
            acc = 64'h0001_0000_0000_0000;
            term = acc;
            for (int n = 1; n <= 20; n++)
            begin
                term = (term * t) / (64'd4096 * n);
                acc += term;
            end
            return acc;
        endfunction

        // e^(x/4096) in unsigned Q12.20
        function longint unsigned weight(int x);
            int unsigned     mag;
            logic [127:0]    prod;
            longint unsigned r;
            longint unsigned d;
            mag = (x < 0) ? -x : x;
            r = exp_q48(mag & 4095);
            for (int i = 0; i < (mag >> 12); i++)
            begin
                prod = 128'(r) * 128'(e_one);
                r = prod[111:48];
            end
            if (x >= 0)
                return (r + (64'd1 << 27)) >> 28;
            d = (r + (64'd1 << 19)) >> 20;
            if (d == 0)
                d = 1;
            return ((64'd1 << 48) + (d >> 1)) / d;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int unsigned v;
            if (idx == REG_FRAME_WIDTH)
            begin
                v = data & 13'h7FF;
                width = (v < 2) ? 2 : (v > 1024) ? 1024 : v;
            end
            else
            begin
                v = data;
                height = (v < 2) ? 2 : (v > 4096) ? 4096 : v;
            end
            row = 0;
            col = 0;
        endfunction

        function void note_sample(logic [15:0] raw);
            int              x;
            int unsigned     ow;
            int unsigned     oh;
            int unsigned     idx;
            longint unsigned w;
            longint          wx;
            longint unsigned mag;
            longint unsigned qm;
            longint          qv;
            pooled_t         res;
            x = $signed(raw);
            ow = width / 2;
            oh = height / 2;
            n_samples++;
            if (col < 2 * ow && row < 2 * oh)
            begin
                idx = (col >> 1) % 512;
                w = weight(x);
                wx = longint'(w) * longint'(x);
                if (row[0] == 0 && col[0] == 0)
                begin
                    wx_line[idx] = wx;
                    w_line[idx] = w;
                end
                else
                begin
                    wx_line[idx] += wx;
                    w_line[idx] += w;
                end
                if (row[0] == 1 && col[0] == 1)
                begin
                    mag = (wx_line[idx] < 0) ? -wx_line[idx] : wx_line[idx];
                    qm = mag / w_line[idx];
                    if (wx_line[idx] < 0)
                        qv = (qm > 32768) ? -32768 : -longint'(qm);
                    else
                        qv = (qm > 32767) ? 32767 : longint'(qm);
                    res.value = qv[15:0];
                    res.last = (row == 2 * oh - 1 && col == 2 * ow - 1);
                    pending.push_back(res);
                end
            end
            col++;
            if (col >= width)
            begin
                col = 0;
                row++;
                if (row >= height)
                    row = 0;
            end
        endfunction

        function void check(logic [15:0] value, logic last);
            pooled_t exp_res;
            n_results++;
            if (pending.size() == 0)
            begin
                $error("unexpected pooled result %h", value);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (value !== exp_res.value)
            begin
                $error("pooled_value: expected %h, got %h", exp_res.value, value);
                errors++;
            end
            if (last !== exp_res.last)
            begin
                $error("last_in_plane: expected %b, got %b", exp_res.last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int SETTLE = 9000;
    localparam int HOLD_LEN = 30000;
    localparam longint LIMIT = 40_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    pool_scoreboard sb = new();
    bit     calm;
    bit     hold_req;
    bit     hold_off;
    longint cycle;
    int     n_phases;

    softmax_weighted_pool_2x2 u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle++;
        if (cycle > LIMIT)
        begin
            $display("** softmax_weighted_pool_2x2: FAILED **");
            $finish;
        end
    end

    // long receiver stall, counted here
    initial
    begin
        hold_off = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_off <= 1'b0;
    end

    // result side: check each transaction, then pick next tready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check(m_tdata, m_tlast);
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
    end

    task automatic send_sample(logic [15:0] x);
        s_tvalid <= 1'b1;
        s_tdata <= x;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_sample(x);
        if (!calm && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        // a sample without a result may still be in work
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random(int n);
        logic [15:0] x;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0: x = 16'($urandom);
                1: x = 16'($urandom_range(0, 8191) - 4096);
                2: x = $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(15))
                                         : 16'h8000 + 16'($urandom_range(15));
                default: x = 16'($urandom_range(0, 511) - 256);
            endcase
            send_sample(x);
        end
    endtask

    initial
    begin
        int w;
        int h;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_FRAME_WIDTH;
        cfg_data = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        cycle = 0;
        n_phases = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: top row only, no results
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        drain();

        write_reg(REG_FRAME_WIDTH, 13'd2);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        send_sample(16'h8000); send_sample(16'h8000);
        send_sample(16'h8000); send_sample(16'h8000);
        send_sample(16'h7FFF); send_sample(16'h7FFF);
        send_sample(16'h8000); send_sample(16'h0001);
        drain();

        // out-of-range values saturate; bits above width field are dropped
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd1);
        send_sample(16'h0000); send_sample(16'h5555);
        send_sample(16'hAAAA); send_sample(16'hFFFF);
        drain();
        write_reg(REG_FRAME_WIDTH, 13'h1FFF);
        write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
        send_sample(16'h1000); send_sample(16'hF000);
        drain();

        // odd width and height: last column and row ignored
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        send_sample(16'h2000); send_sample(16'hE000); send_sample(16'h7FFF);
        send_sample(16'h0800); send_sample(16'hF800); send_sample(16'h8000);
        send_sample(16'h7FFF); send_sample(16'h8000); send_sample(16'h1234);
        drain();

        while (sb.n_samples < 700)
        begin
            n_phases++;
            calm = (n_phases >= 6 && n_phases <= 8);
            w = ($urandom_range(9) == 0) ? 2 * $urandom_range(1, 4) + 1
                                         : $urandom_range(2, 8);
            h = $urandom_range(2, 6);
            if ($urandom_range(1))
            begin
                write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
                write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
            end
            else
            begin
                write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
                write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
            end
            if (n_phases == 3)
                hold_req = 1'b1;
            send_random(sb.width * sb.height * $urandom_range(1, 3)
                        + ($urandom_range(3) == 0 ? $urandom_range(1, 5) : 0));
            drain();
        end
        calm = 1'b0;

        $display("Covered %0d samples and %0d pooled results over %0d random geometries,",
                 sb.n_samples, sb.n_results, n_phases);
        $display("with saturated register writes, odd edges and a long output stall.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** softmax_weighted_pool_2x2: PASSED **");
        else
            $display("** softmax_weighted_pool_2x2: FAILED **");
        $finish;
    end
endmodule
